// ===== hdl/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
//
// Pool geometry, operation and status codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pls_pkg;

  // Pool geometry. A link equal to NIL marks the end of the list.
  localparam int CAPACITY  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int LINK_W    = $clog2(CAPACITY + 1);
  localparam int CNT_W     = LINK_W;
  localparam int POS_W     = 8;
  localparam int VAL_W     = 32;
  localparam int OUT_CNT_W = 5;
  localparam int CMP_W     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

  // Operation codes.
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_SEARCH    = 3'd6
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Source of the node read address.
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_TAIL = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    step_clr;
    logic    step_inc;
    logic    ld_front;
    logic    ld_back;
    logic    cap_ins;
    logic    cap_del;
    logic    wr_new;
    logic    wr_nbr;
    logic    unlink;
    logic    st_set;
    status_t st_code;
    logic    found_set;
    logic    out_load;
  } pls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic full;
    logic pos_zero;
    logic pos_gt_cnt;
    logic pos_gt_cnt1;
    logic pos_eq_cnt1;
    logic step_eq_pos;
    logic step_eq_cnt;
    logic key_match;
  } pls_stat_t;

endpackage

// ===== hdl/pls_datapath.sv =====
// ----------------------------------------------------------------------------
// pls_datapath: node pool, list pointers and result registers
//
// Holds the node memories, head, tail, occupancy map and entry count, walks
// the list one node per cycle and applies link updates on command.
// ----------------------------------------------------------------------------
module pls_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pls_pkg::pls_cmd_t                    cmd,
  output pls_pkg::pls_stat_t                   stat,
  input  logic [2:0]                           operation,
  input  logic signed [pls_pkg::VAL_W-1:0]     value,
  input  logic [pls_pkg::POS_W-1:0]            position,
  output logic [2:0]                           status,
  output logic signed [pls_pkg::VAL_W-1:0]     removed_value,
  output logic [pls_pkg::OUT_CNT_W-1:0]        found_position,
  output logic [pls_pkg::OUT_CNT_W-1:0]        entry_count
);

  // Node memories.
  logic signed [pls_pkg::VAL_W-1:0]  val_mem [pls_pkg::CAPACITY];
  logic [pls_pkg::LINK_W-1:0]        fwd_mem [pls_pkg::CAPACITY];
  logic [pls_pkg::LINK_W-1:0]        bwd_mem [pls_pkg::CAPACITY];

  // List state.
  logic [pls_pkg::LINK_W-1:0]   head;
  logic [pls_pkg::LINK_W-1:0]   tail;
  logic [pls_pkg::CAPACITY-1:0] occupied;
  logic [pls_pkg::CNT_W-1:0]    count;

  // Latched transaction fields.
  pls_pkg::op_t                     op_q;
  logic signed [pls_pkg::VAL_W-1:0] key;
  logic [pls_pkg::POS_W-1:0]        pos_q;

  // Walk and link working registers.
  logic [pls_pkg::CNT_W-1:0]        step;
  logic [pls_pkg::LINK_W-1:0]       cur;
  logic signed [pls_pkg::VAL_W-1:0] val_q;
  logic [pls_pkg::LINK_W-1:0]       fwd_q;
  logic [pls_pkg::LINK_W-1:0]       bwd_q;
  logic [pls_pkg::LINK_W-1:0]       after_idx;
  logic [pls_pkg::LINK_W-1:0]       before_idx;
  logic [pls_pkg::IDX_W-1:0]        slot;

  // Result registers of the current transaction.
  pls_pkg::status_t                 res_status;
  logic signed [pls_pkg::VAL_W-1:0] res_removed;
  logic [pls_pkg::CNT_W-1:0]        res_found;

  logic [pls_pkg::LINK_W-1:0] rd_addr;
  logic [pls_pkg::IDX_W-1:0]  free_idx;

  logic                       fwd_we;
  logic [pls_pkg::IDX_W-1:0]  fwd_wa;
  logic [pls_pkg::LINK_W-1:0] fwd_wd;
  logic                       bwd_we;
  logic [pls_pkg::IDX_W-1:0]  bwd_wa;
  logic [pls_pkg::LINK_W-1:0] bwd_wd;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = pls_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (!occupied[i]) begin
        free_idx = pls_pkg::IDX_W'(i);
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.op          = op_q;
    stat.count_zero  = (count == '0);
    stat.full        = &occupied;
    stat.pos_zero    = (pos_q == '0);
    stat.pos_gt_cnt  = (pls_pkg::CMP_W'(pos_q) > pls_pkg::CMP_W'(count));
    stat.pos_gt_cnt1 = (pls_pkg::CMP_W'(pos_q) >
                        (pls_pkg::CMP_W'(count) + pls_pkg::CMP_W'(1)));
    stat.pos_eq_cnt1 = (pls_pkg::CMP_W'(pos_q) ==
                        (pls_pkg::CMP_W'(count) + pls_pkg::CMP_W'(1)));
    stat.step_eq_pos = (pls_pkg::CMP_W'(step) == pls_pkg::CMP_W'(pos_q));
    stat.step_eq_cnt = (step == count);
    stat.key_match   = (val_q == key);
  end

  // Read address: head, tail, or the successor of the node just read.
  always_comb begin
    case (cmd.rd_sel)
      pls_pkg::RD_HEAD: rd_addr = head;
      pls_pkg::RD_TAIL: rd_addr = tail;
      pls_pkg::RD_NEXT: rd_addr = fwd_q;
      default:          rd_addr = head;
    endcase
  end

  // Link write ports. A new node writes its own links; the neighbor pass
  // and the unlink pass patch the nodes on either side.
  always_comb begin
    fwd_we = 1'b0;
    fwd_wa = slot;
    fwd_wd = after_idx;
    bwd_we = 1'b0;
    bwd_wa = slot;
    bwd_wd = before_idx;
    if (cmd.wr_new) begin
      fwd_we = 1'b1;
      bwd_we = 1'b1;
    end else if (cmd.wr_nbr) begin
      fwd_we = (before_idx != pls_pkg::NIL);
      fwd_wa = before_idx[pls_pkg::IDX_W-1:0];
      fwd_wd = pls_pkg::LINK_W'(slot);
      bwd_we = (after_idx != pls_pkg::NIL);
      bwd_wa = after_idx[pls_pkg::IDX_W-1:0];
      bwd_wd = pls_pkg::LINK_W'(slot);
    end else if (cmd.unlink) begin
      fwd_we = (before_idx != pls_pkg::NIL);
      fwd_wa = before_idx[pls_pkg::IDX_W-1:0];
      fwd_wd = after_idx;
      bwd_we = (after_idx != pls_pkg::NIL);
      bwd_wa = after_idx[pls_pkg::IDX_W-1:0];
      bwd_wd = before_idx;
    end
  end

  // Value memory.
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      val_mem[slot] <= key;
    end
    if (cmd.rd_en) begin
      val_q <= val_mem[rd_addr[pls_pkg::IDX_W-1:0]];
    end
  end

  // Forward link memory.
  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_wa] <= fwd_wd;
    end
    if (cmd.rd_en) begin
      fwd_q <= fwd_mem[rd_addr[pls_pkg::IDX_W-1:0]];
    end
  end

  // Backward link memory.
  always_ff @(posedge clk) begin
    if (bwd_we) begin
      bwd_mem[bwd_wa] <= bwd_wd;
    end
    if (cmd.rd_en) begin
      bwd_q <= bwd_mem[rd_addr[pls_pkg::IDX_W-1:0]];
    end
  end

  // Head, tail, occupancy and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= pls_pkg::NIL;
      tail     <= pls_pkg::NIL;
      occupied <= '0;
      count    <= '0;
    end else begin
      if (cmd.wr_new) begin
        occupied[slot] <= 1'b1;
      end
      if (cmd.wr_nbr) begin
        if (before_idx == pls_pkg::NIL) begin
          head <= pls_pkg::LINK_W'(slot);
        end
        if (after_idx == pls_pkg::NIL) begin
          tail <= pls_pkg::LINK_W'(slot);
        end
        count <= count + pls_pkg::CNT_W'(1);
      end
      if (cmd.unlink) begin
        if (before_idx == pls_pkg::NIL) begin
          head <= after_idx;
        end
        if (after_idx == pls_pkg::NIL) begin
          tail <= before_idx;
        end
        occupied[slot] <= 1'b0;
        count          <= count - pls_pkg::CNT_W'(1);
      end
    end
  end

  // Transaction fields, walk position and link working registers.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q        <= pls_pkg::op_t'(operation);
      key         <= value;
      pos_q       <= position;
      res_status  <= pls_pkg::ST_OK;
      res_removed <= '0;
      res_found   <= '0;
    end
    if (cmd.rd_en) begin
      cur <= rd_addr;
    end
    if (cmd.step_clr) begin
      step <= pls_pkg::CNT_W'(1);
    end else if (cmd.step_inc) begin
      step <= step + pls_pkg::CNT_W'(1);
    end
    if (cmd.ld_front) begin
      after_idx  <= head;
      before_idx <= pls_pkg::NIL;
      slot       <= free_idx;
    end
    if (cmd.ld_back) begin
      after_idx  <= pls_pkg::NIL;
      before_idx <= tail;
      slot       <= free_idx;
    end
    if (cmd.cap_ins) begin
      after_idx  <= cur;
      before_idx <= bwd_q;
      slot       <= free_idx;
    end
    if (cmd.cap_del) begin
      after_idx   <= fwd_q;
      before_idx  <= bwd_q;
      slot        <= cur[pls_pkg::IDX_W-1:0];
      res_removed <= val_q;
    end
    if (cmd.st_set) begin
      res_status <= cmd.st_code;
    end
    if (cmd.found_set) begin
      res_found <= step;
    end
  end

  // Output register, loaded once the result is complete.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= res_status;
      removed_value  <= res_removed;
      found_position <= pls_pkg::OUT_CNT_W'(res_found);
      entry_count    <= pls_pkg::OUT_CNT_W'(count);
    end
  end

endmodule

// ===== hdl/pls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pls_ctrl: operation sequencer of the positional list store
//
// Accepts one transaction at a time, checks it, steers the list walk and the
// link updates, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pls_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  pls_pkg::pls_stat_t  stat,
  output pls_pkg::pls_cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_WR_NEW = 7'b0001000,
    S_WR_NBR = 7'b0010000,
    S_UNLINK = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_DECODE;
        end
      end

      // Range, fullness and emptiness checks; start a walk where needed.
      S_DECODE: begin
        state_next = S_FINISH;
        case (stat.op)
          pls_pkg::OP_INS_FRONT: begin
            if (stat.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pls_pkg::ST_FULL;
            end else begin
              cmd.ld_front = 1'b1;
              state_next   = S_WR_NEW;
            end
          end
          pls_pkg::OP_INS_BACK: begin
            if (stat.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pls_pkg::ST_FULL;
            end else begin
              cmd.ld_back = 1'b1;
              state_next  = S_WR_NEW;
            end
          end
          pls_pkg::OP_INS_POS: begin
            if (stat.pos_zero || stat.pos_gt_cnt1) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pls_pkg::ST_RANGE;
            end else if (stat.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pls_pkg::ST_FULL;
            end else if (stat.pos_eq_cnt1) begin
              cmd.ld_back = 1'b1;
              state_next  = S_WR_NEW;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = pls_pkg::RD_HEAD;
              cmd.step_clr = 1'b1;
              state_next   = S_WALK;
            end
          end
          pls_pkg::OP_DEL_FRONT, pls_pkg::OP_DEL_BACK: begin
            if (stat.count_zero) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pls_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = (stat.op == pls_pkg::OP_DEL_BACK) ? pls_pkg::RD_TAIL
                                                               : pls_pkg::RD_HEAD;
              cmd.step_clr = 1'b1;
              state_next   = S_WALK;
            end
          end
          pls_pkg::OP_DEL_POS: begin
            if (stat.count_zero) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pls_pkg::ST_EMPTY;
            end else if (stat.pos_zero || stat.pos_gt_cnt) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pls_pkg::ST_RANGE;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = pls_pkg::RD_HEAD;
              cmd.step_clr = 1'b1;
              state_next   = S_WALK;
            end
          end
          pls_pkg::OP_SEARCH: begin
            if (stat.count_zero) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = pls_pkg::ST_NOT_FOUND;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = pls_pkg::RD_HEAD;
              cmd.step_clr = 1'b1;
              state_next   = S_WALK;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end

      // One node per cycle: the node read last cycle is checked here.
      S_WALK: begin
        if (stat.op == pls_pkg::OP_SEARCH) begin
          if (stat.key_match) begin
            cmd.found_set = 1'b1;
            state_next    = S_FINISH;
          end else if (stat.step_eq_cnt) begin
            cmd.st_set  = 1'b1;
            cmd.st_code = pls_pkg::ST_NOT_FOUND;
            state_next  = S_FINISH;
          end else begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = pls_pkg::RD_NEXT;
            cmd.step_inc = 1'b1;
          end
        end else if (stat.step_eq_pos || stat.op == pls_pkg::OP_DEL_FRONT ||
                     stat.op == pls_pkg::OP_DEL_BACK) begin
          if (stat.op == pls_pkg::OP_INS_POS) begin
            cmd.cap_ins = 1'b1;
            state_next  = S_WR_NEW;
          end else begin
            cmd.cap_del = 1'b1;
            state_next  = S_UNLINK;
          end
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = pls_pkg::RD_NEXT;
          cmd.step_inc = 1'b1;
        end
      end

      S_WR_NEW: begin
        cmd.wr_new = 1'b1;
        state_next = S_WR_NBR;
      end

      S_WR_NBR: begin
        cmd.wr_nbr = 1'b1;
        state_next = S_FINISH;
      end

      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_FINISH;
      end

      // Hand the result over once the output register is free.
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of signed values in a linked node pool
//
// Usage: a request transaction (operation, value, position) is taken on the
// req channel when req_valid is high and req_stall is low. Each request gives
// exactly one response transaction (status, removed_value, found_position,
// entry_count) on the rsp channel, taken when rsp_valid is high and rsp_stall
// is low. One request is in work at a time; req_stall is high while it is.
// A request is decoded and checked first. A rejected request, an unused
// operation code or a search of an empty list goes straight to the result.
// Inserts at the front or back (an insert just past the end counts as one
// at the back) write the new node and then patch its neighbours; all other
// operations walk the list one node per cycle through the registered read
// port. req_stall falls in the same cycle in which rsp_valid rises.
// A finished response waits in the output register while rsp_stall is high;
// the next request is accepted meanwhile and its own response waits until
// that register is free. Reset empties the list at once: no entries, every
// slot free, no response pending.
// ----------------------------------------------------------------------------
module positional_list_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [2:0]                        operation,
  input  logic signed [pls_pkg::VAL_W-1:0]  value,
  input  logic [pls_pkg::POS_W-1:0]         position,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [2:0]                        status,
  output logic signed [pls_pkg::VAL_W-1:0]  removed_value,
  output logic [pls_pkg::OUT_CNT_W-1:0]     found_position,
  output logic [pls_pkg::OUT_CNT_W-1:0]     entry_count
);

  pls_pkg::pls_cmd_t  cmd;
  pls_pkg::pls_stat_t stat;

  // Sequencer.
  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Node pool and result registers.
  pls_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (operation),
    .value          (value),
    .position       (position),
    .status         (status),
    .removed_value  (removed_value),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

endmodule
